>>> rtl/euler_camera_view_matrix_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the camera view matrix unit
// Wraps clocked implication checks with reset disable and error reporting.
// ----------------------------------------------------------------------------
`ifndef EULER_CAMERA_VIEW_MATRIX_UNIT_ASSERT_SVH
`define EULER_CAMERA_VIEW_MATRIX_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ECVM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ecvm same-cycle check failed");

// Next-cycle implication.
`define ECVM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ecvm next-cycle check failed");

`endif

>>> rtl/ecvm_pkg.sv
// ----------------------------------------------------------------------------
// ecvm_pkg
// Shared types and constants of the camera view matrix unit.
// ----------------------------------------------------------------------------
package ecvm_pkg;

    localparam int QUARTER_UNITS = 11520;
    localparam int FULL_UNITS    = 46080;

    localparam int ANG_LAT  = 3;
    localparam int SIN_LAT  = 10;
    localparam int VIEW_LAT = 4;
    localparam int PIPE_LAT = ANG_LAT + SIN_LAT + VIEW_LAT;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_OFF_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_OFF_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_OFF_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_OFF   = 3'd4;

    localparam int TRIG_SP = 0;
    localparam int TRIG_CP = 1;
    localparam int TRIG_SY = 2;
    localparam int TRIG_CY = 3;

    typedef struct packed {
        logic signed [31:0] pos_off_x;
        logic signed [31:0] pos_off_y;
        logic signed [31:0] pos_off_z;
        logic signed [15:0] pitch_off;
        logic signed [15:0] yaw_off;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_item;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_eye;

    typedef struct packed {
        logic [3:0][13:0] r;
        logic [3:0]       neg;
        t_eye             eye;
    } t_ang;

    typedef struct packed {
        logic signed [15:0] sp;
        logic signed [15:0] cp;
        logic signed [15:0] sy;
        logic signed [15:0] cy;
    } t_trig;

    typedef struct packed {
        logic signed [15:0] side_x;
        logic signed [15:0] side_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] back_x;
        logic signed [15:0] back_y;
        logic signed [15:0] back_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic               degenerate;
    } t_view;

endpackage

>>> rtl/ecvm_if.sv
// ----------------------------------------------------------------------------
// ecvm_if
// Valid/ready channels of the camera view matrix unit.
// ----------------------------------------------------------------------------
interface ecvm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] obj_pos_x;
    logic signed [31:0] obj_pos_y;
    logic signed [31:0] obj_pos_z;
    logic signed [15:0] obj_pitch;
    logic signed [15:0] obj_yaw;

    modport source(output valid, obj_pos_x, obj_pos_y, obj_pos_z, obj_pitch, obj_yaw,
                   input ready);
    modport sink(input valid, obj_pos_x, obj_pos_y, obj_pos_z, obj_pitch, obj_yaw,
                 output ready);
endinterface

interface ecvm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] side_x;
    logic signed [15:0] side_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic               degenerate;

    modport source(output valid, side_x, side_z, up_x, up_y, up_z, back_x, back_y, back_z,
                   trans_x, trans_y, trans_z, degenerate, input ready);
    modport sink(input valid, side_x, side_z, up_x, up_y, up_z, back_x, back_y, back_z,
                 trans_x, trans_y, trans_z, degenerate, output ready);
endinterface

interface ecvm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/ecvm_angle.sv
// ----------------------------------------------------------------------------
// ecvm_angle
// Adds offsets, wraps the angles to one turn and splits them into quadrants.
// ----------------------------------------------------------------------------
module ecvm_angle
    import ecvm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cfg  i_cfg,
    input  t_item i_item,
    output t_ang  o_ang
);

    function automatic logic [15:0] f_wrap(input logic signed [17:0] a);
        logic signed [18:0] t;
        t = 19'(a);
        if (t < -FULL_UNITS) begin
            t = t + 19'(2 * FULL_UNITS);
        end else if (t < 0) begin
            t = t + 19'(FULL_UNITS);
        end else if (t >= FULL_UNITS) begin
            t = t - 19'(FULL_UNITS);
        end
        return t[15:0];
    endfunction

    function automatic logic [15:0] f_quarter_turn(input logic [15:0] a);
        logic [16:0] t;
        t = 17'(a) + 17'(QUARTER_UNITS);
        if (t >= 17'(FULL_UNITS)) begin
            t = t - 17'(FULL_UNITS);
        end
        return t[15:0];
    endfunction

    logic signed [17:0] r_pit_sum;
    logic signed [17:0] r_yaw_sum;
    t_eye               r_eye1;
    logic [3:0][15:0]   r_ang;
    t_eye               r_eye2;
    t_ang               r_out;

    logic [15:0] n_pa;
    logic [15:0] n_ya;
    t_ang        n_out;

    always_comb begin
        n_pa = f_wrap(r_pit_sum);
        n_ya = f_wrap(r_yaw_sum);
    end

    always_comb begin
        logic [1:0]  q;
        logic [15:0] rem;
        n_out     = r_out;
        n_out.eye = r_eye2;
        for (int k = 0; k < 4; k++) begin
            if (r_ang[k] >= 16'(3 * QUARTER_UNITS)) begin
                q   = 2'd3;
                rem = r_ang[k] - 16'(3 * QUARTER_UNITS);
            end else if (r_ang[k] >= 16'(2 * QUARTER_UNITS)) begin
                q   = 2'd2;
                rem = r_ang[k] - 16'(2 * QUARTER_UNITS);
            end else if (r_ang[k] >= 16'(QUARTER_UNITS)) begin
                q   = 2'd1;
                rem = r_ang[k] - 16'(QUARTER_UNITS);
            end else begin
                q   = 2'd0;
                rem = r_ang[k];
            end
            if (q[0]) begin
                rem = 16'(QUARTER_UNITS) - rem;
            end
            n_out.r[k]   = rem[13:0];
            n_out.neg[k] = q[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_eye1.x  <= 33'(i_item.pos_x) + 33'(i_cfg.pos_off_x);
            r_eye1.y  <= 33'(i_item.pos_y) + 33'(i_cfg.pos_off_y);
            r_eye1.z  <= 33'(i_item.pos_z) + 33'(i_cfg.pos_off_z);
            r_pit_sum <= 18'(i_item.pitch) + 18'(i_cfg.pitch_off);
            r_yaw_sum <= -(18'(i_item.yaw) + 18'(i_cfg.yaw_off));
            r_ang[TRIG_SP] <= n_pa;
            r_ang[TRIG_CP] <= f_quarter_turn(n_pa);
            r_ang[TRIG_SY] <= n_ya;
            r_ang[TRIG_CY] <= f_quarter_turn(n_ya);
            r_eye2 <= r_eye1;
            r_out  <= n_out;
        end
    end

    assign o_ang = r_out;

endmodule

>>> rtl/ecvm_sin.sv
// ----------------------------------------------------------------------------
// ecvm_sin
// Pipelined quadrant sine: scales the angle to Q30 and runs the odd
// polynomial in Horner form, one multiplication per stage.
// ----------------------------------------------------------------------------
module ecvm_sin
    import ecvm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [13:0]        i_r,
    input  logic               i_neg,
    output logic signed [15:0] o_val
);

    localparam int XDIV      = QUARTER_UNITS / 256;
    localparam int XSH       = 22;
    localparam int RECIP     = 23302;
    localparam int RECIP_SH  = 20;
    localparam int ONE_Q14   = 16384;

    localparam logic signed [32:0] C1 = 33'sd1686629713;
    localparam logic signed [32:0] C3 = 33'sd693598668;
    localparam logic signed [32:0] C5 = 33'sd85569306;
    localparam logic signed [32:0] C7 = 33'sd5026995;
    localparam logic signed [32:0] C9 = 33'sd172272;

    typedef logic [22:0] t_xtab [XDIV];

    function automatic t_xtab f_build_xtab();
        t_xtab t;
        for (int i = 0; i < XDIV; i++) begin
            t[i] = 23'((longint'(i) * (longint'(1) << XSH) + longint'(XDIV / 2)) / XDIV);
        end
        return t;
    endfunction

    localparam t_xtab XTAB = f_build_xtab();

    function automatic logic signed [32:0] f_mq30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] pr;
        logic [65:0]        m;
        pr = 66'(a) * 66'(b);
        m  = pr[65] ? 66'(-pr) : 66'(pr);
        m  = (m + (66'd1 << 29)) >> 30;
        return pr[65] ? -33'(m) : 33'(m);
    endfunction

    logic [8:0]         r1_a;
    logic [13:0]        r1_r;
    logic [8:0]         r2_a;
    logic [5:0]         r2_b;
    logic signed [32:0] r3_x;
    logic signed [32:0] r4_x;
    logic signed [32:0] r4_x2;
    logic signed [32:0] r5_x;
    logic signed [32:0] r5_x2;
    logic signed [32:0] r5_p;
    logic signed [32:0] r6_x;
    logic signed [32:0] r6_x2;
    logic signed [32:0] r6_p;
    logic signed [32:0] r7_x;
    logic signed [32:0] r7_x2;
    logic signed [32:0] r7_p;
    logic signed [32:0] r8_x;
    logic signed [32:0] r8_p;
    logic signed [32:0] r9_p;
    logic signed [15:0] r10_v;
    logic [SIN_LAT-2:0] r_neg;

    logic [28:0]        n_prod;
    logic [32:0]        n_rnd;
    logic [16:0]        n_q;
    logic signed [15:0] n_v;

    always_comb begin
        n_prod = 29'(i_r) * 29'(RECIP);
        n_rnd  = 33'(r9_p) + 33'd32768;
        n_q    = 17'(n_rnd >> 16);
        if (r9_p <= 0) begin
            n_q = '0;
        end else if (n_q > 17'(ONE_Q14)) begin
            n_q = 17'(ONE_Q14);
        end
        n_v = r_neg[SIN_LAT-2] ? -16'(n_q) : 16'(n_q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a  <= 9'(n_prod >> RECIP_SH);
            r1_r  <= i_r;
            r2_a  <= r1_a;
            r2_b  <= 6'(r1_r - 14'(14'(r1_a) * 14'(XDIV)));
            r3_x  <= 33'({r2_a, XSH'(0)}) + 33'(XTAB[r2_b]);
            r4_x  <= r3_x;
            r4_x2 <= f_mq30(r3_x, r3_x);
            r5_x  <= r4_x;
            r5_x2 <= r4_x2;
            r5_p  <= f_mq30(C9, r4_x2) - C7;
            r6_x  <= r5_x;
            r6_x2 <= r5_x2;
            r6_p  <= f_mq30(r5_p, r5_x2) + C5;
            r7_x  <= r6_x;
            r7_x2 <= r6_x2;
            r7_p  <= f_mq30(r6_p, r6_x2) - C3;
            r8_x  <= r7_x;
            r8_p  <= f_mq30(r7_p, r7_x2) + C1;
            r9_p  <= f_mq30(r8_p, r8_x);
            r10_v <= n_v;
            r_neg <= {r_neg[SIN_LAT-3:0], i_neg};
        end
    end

    assign o_val = r10_v;

endmodule

>>> rtl/ecvm_view.sv
// ----------------------------------------------------------------------------
// ecvm_view
// Builds the side, up and front vectors and the saturated translation.
// ----------------------------------------------------------------------------
module ecvm_view
    import ecvm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_trig i_trig,
    input  t_eye  i_eye,
    output t_view o_res
);

    localparam logic signed [37:0] SAT_HI = 38'sd2147483647;
    localparam logic signed [37:0] SAT_LO = -38'sd2147483648;

    function automatic logic signed [15:0] f_mq14(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        logic signed [31:0] pr;
        logic [31:0]        m;
        pr = 32'(a) * 32'(b);
        m  = pr[31] ? 32'(-pr) : 32'(pr);
        m  = (m + 32'd8192) >> 14;
        return pr[31] ? -16'(m) : 16'(m);
    endfunction

    function automatic logic signed [37:0] f_rnd14(input logic signed [50:0] v);
        logic [50:0] m;
        m = v[50] ? 51'(-v) : 51'(v);
        m = (m + 51'd8192) >> 14;
        return v[50] ? -38'(m) : 38'(m);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [37:0] v);
        if (v > SAT_HI) begin
            return 32'(SAT_HI);
        end else if (v < SAT_LO) begin
            return 32'(SAT_LO);
        end
        return 32'(v);
    endfunction

    t_trig              r1_trig;
    logic signed [15:0] r1_cysp;
    logic signed [15:0] r1_sysp;
    logic signed [15:0] r1_cycp;
    logic signed [15:0] r1_sycp;
    t_eye               r1_eye;

    logic signed [15:0] r2_sx, r2_sz, r2_ux, r2_uy, r2_uz, r2_fx, r2_fy, r2_fz;
    logic               r2_degen;
    t_eye               r2_eye;

    logic signed [15:0] r3_sx, r3_sz, r3_ux, r3_uy, r3_uz, r3_fx, r3_fy, r3_fz;
    logic               r3_degen;
    logic signed [48:0] r3_sxe, r3_sze, r3_uxe, r3_uye, r3_uze, r3_fxe, r3_fye, r3_fze;

    t_view r4_res;

    logic  n_pos;
    t_view n_res;

    assign n_pos = r1_trig.cp > 16'sd0;

    always_comb begin
        logic signed [50:0] sum_x;
        logic signed [50:0] sum_y;
        logic signed [50:0] sum_z;
        sum_x = 51'(r3_sxe) + 51'(r3_sze);
        sum_y = 51'(r3_uxe) + 51'(r3_uye) + 51'(r3_uze);
        sum_z = 51'(r3_fxe) + 51'(r3_fye) + 51'(r3_fze);
        n_res            = '0;
        n_res.degenerate = r3_degen;
        if (!r3_degen) begin
            n_res.side_x  = r3_sx;
            n_res.side_z  = r3_sz;
            n_res.up_x    = r3_ux;
            n_res.up_y    = r3_uy;
            n_res.up_z    = r3_uz;
            n_res.back_x  = -r3_fx;
            n_res.back_y  = -r3_fy;
            n_res.back_z  = -r3_fz;
            n_res.trans_x = f_sat32(-f_rnd14(sum_x));
            n_res.trans_y = f_sat32(-f_rnd14(sum_y));
            n_res.trans_z = f_sat32(f_rnd14(sum_z));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_trig  <= i_trig;
            r1_cysp  <= f_mq14(i_trig.cy, i_trig.sp);
            r1_sysp  <= f_mq14(i_trig.sy, i_trig.sp);
            r1_cycp  <= f_mq14(i_trig.cy, i_trig.cp);
            r1_sycp  <= f_mq14(i_trig.sy, i_trig.cp);
            r1_eye   <= i_eye;

            r2_sx    <= n_pos ? -r1_trig.sy : r1_trig.sy;
            r2_sz    <= n_pos ? r1_trig.cy : -r1_trig.cy;
            r2_ux    <= n_pos ? -r1_cysp : r1_cysp;
            r2_uy    <= n_pos ? r1_trig.cp : -r1_trig.cp;
            r2_uz    <= n_pos ? -r1_sysp : r1_sysp;
            r2_fx    <= r1_cycp;
            r2_fy    <= r1_trig.sp;
            r2_fz    <= r1_sycp;
            r2_degen <= r1_trig.cp == 16'sd0;
            r2_eye   <= r1_eye;

            r3_sx    <= r2_sx;
            r3_sz    <= r2_sz;
            r3_ux    <= r2_ux;
            r3_uy    <= r2_uy;
            r3_uz    <= r2_uz;
            r3_fx    <= r2_fx;
            r3_fy    <= r2_fy;
            r3_fz    <= r2_fz;
            r3_degen <= r2_degen;
            r3_sxe   <= 49'(r2_sx) * 49'(r2_eye.x);
            r3_sze   <= 49'(r2_sz) * 49'(r2_eye.z);
            r3_uxe   <= 49'(r2_ux) * 49'(r2_eye.x);
            r3_uye   <= 49'(r2_uy) * 49'(r2_eye.y);
            r3_uze   <= 49'(r2_uz) * 49'(r2_eye.z);
            r3_fxe   <= 49'(r2_fx) * 49'(r2_eye.x);
            r3_fye   <= 49'(r2_fy) * 49'(r2_eye.y);
            r3_fze   <= 49'(r2_fz) * 49'(r2_eye.z);

            r4_res   <= n_res;
        end
    end

    assign o_res = r4_res;

endmodule

>>> rtl/euler_camera_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// euler_camera_view_matrix_unit
// Takes one camera pose per cycle while the output is not stalled and
// returns its look-at view matrix after angle reduction, the pipelined
// sine polynomial (six chained Q30 multiplications after the Q30 scaling)
// and the vector and translation arithmetic. The whole pipeline
// holds while a finished result is not taken; configuration writes are
// taken at once and should be made while the pipeline is empty.
// ----------------------------------------------------------------------------
`include "euler_camera_view_matrix_unit_assert.svh"

module euler_camera_view_matrix_unit
    import ecvm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ecvm_in_if.sink    i_in,
    ecvm_out_if.source o_out,
    ecvm_cfg_if.sink   i_cfg
);

    t_cfg                r_cfg;
    logic [PIPE_LAT-1:0] r_vld;
    t_eye                r_eye_dly [SIN_LAT];

    logic  w_en;
    t_item w_item;
    t_ang  w_ang;
    t_trig w_trig;
    t_view w_res;
    logic signed [15:0] w_sin [4];

    assign w_en        = !r_vld[PIPE_LAT-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    assign w_item.pos_x = i_in.obj_pos_x;
    assign w_item.pos_y = i_in.obj_pos_y;
    assign w_item.pos_z = i_in.obj_pos_z;
    assign w_item.pitch = i_in.obj_pitch;
    assign w_item.yaw   = i_in.obj_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_POS_OFF_X: r_cfg.pos_off_x <= i_cfg.data;
                REG_POS_OFF_Y: r_cfg.pos_off_y <= i_cfg.data;
                REG_POS_OFF_Z: r_cfg.pos_off_z <= i_cfg.data;
                REG_PITCH_OFF: r_cfg.pitch_off <= i_cfg.data[15:0];
                REG_YAW_OFF:   r_cfg.yaw_off   <= i_cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in.valid};
        end
    end

    ecvm_angle u_angle (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cfg  (r_cfg),
        .i_item (w_item),
        .o_ang  (w_ang)
    );

    for (genvar g = 0; g < 4; g++) begin : g_sin
        ecvm_sin u_sin (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_r   (w_ang.r[g]),
            .i_neg (w_ang.neg[g]),
            .o_val (w_sin[g])
        );
    end

    assign w_trig.sp = w_sin[TRIG_SP];
    assign w_trig.cp = w_sin[TRIG_CP];
    assign w_trig.sy = w_sin[TRIG_SY];
    assign w_trig.cy = w_sin[TRIG_CY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_eye_dly[0] <= w_ang.eye;
            for (int k = 1; k < SIN_LAT; k++) begin
                r_eye_dly[k] <= r_eye_dly[k-1];
            end
        end
    end

    ecvm_view u_view (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_trig (w_trig),
        .i_eye  (r_eye_dly[SIN_LAT-1]),
        .o_res  (w_res)
    );

    assign o_out.valid      = r_vld[PIPE_LAT-1];
    assign o_out.side_x     = w_res.side_x;
    assign o_out.side_z     = w_res.side_z;
    assign o_out.up_x       = w_res.up_x;
    assign o_out.up_y       = w_res.up_y;
    assign o_out.up_z       = w_res.up_z;
    assign o_out.back_x     = w_res.back_x;
    assign o_out.back_y     = w_res.back_y;
    assign o_out.back_z     = w_res.back_z;
    assign o_out.trans_x    = w_res.trans_x;
    assign o_out.trans_y    = w_res.trans_y;
    assign o_out.trans_z    = w_res.trans_z;
    assign o_out.degenerate = w_res.degenerate;

    `ECVM_ASSERT_NXT(a_stall_freezes_pipe, i_clk, i_rst_n, o_out.valid && !o_out.ready, $stable(r_vld))
    `ECVM_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_out.valid && o_out.degenerate, o_out.up_y == 16'sd0 && o_out.trans_x == 32'sd0 && o_out.trans_z == 32'sd0)
    `ECVM_ASSERT_IMP(a_up_y_positive, i_clk, i_rst_n, o_out.valid && !o_out.degenerate, o_out.up_y > 16'sd0)

endmodule

>>> tb/tb_euler_camera_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// Camera view matrix unit testbench
// Drives camera poses through the valid/ready channels, predicts every view
// matrix in fixed point and compares each transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
    int side_x, side_z, up_x, up_y, up_z, back_x, back_y, back_z;
    int trans_x, trans_y, trans_z;
    bit degenerate;
} t_view_rec;

class t_view_scoreboard;
    longint off_x, off_y, off_z, off_pitch, off_yaw;
    t_view_rec pending[$];
    int errors;
    int results;
    int degenerate_seen;

    function new();
        off_x = 0; off_y = 0; off_z = 0; off_pitch = 0; off_yaw = 0;
        errors = 0; results = 0; degenerate_seen = 0;
    endfunction

    static function longint round_shift(longint v, int n);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (n - 1))) >>> n;
        return (v < 0) ? -m : m;
    endfunction

    static function longint quadrant_sine(longint r);
        longint x, x2, p, q;
        x = ((r << 30) + 5760) / 11520;
        x2 = round_shift(x * x, 30);
        p = 172272;
        p = round_shift(p * x2, 30) - 5026995;
        p = round_shift(p * x2, 30) + 85569306;
        p = round_shift(p * x2, 30) - 693598668;
        p = round_shift(p * x2, 30) + 1686629713;
        p = round_shift(p * x, 30);
        if (p <= 0) return 0;
        q = (p + 32768) >>> 16;
        return (q > 16384) ? 16384 : q;
    endfunction

    static function longint sine_of(longint a);
        longint q, r, v;
        q = a / 11520;
        r = a % 11520;
        if (q[0]) r = 11520 - r;
        v = quadrant_sine(r);
        return (q >= 2) ? -v : v;
    endfunction

    static function longint wrap_degrees(longint a);
        longint r;
        r = a % 46080;
        return (r < 0) ? r + 46080 : r;
    endfunction

    static function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function void note_pose(int px, int py, int pz, shortint pitch, shortint yaw);
        longint ex, ey, ez, pa, ya, sp, cp, sy, cy, s, sx, sz, ux, uy, uz, fx, fy, fz;
        t_view_rec v;
        ex = longint'(px) + off_x;
        ey = longint'(py) + off_y;
        ez = longint'(pz) + off_z;
        pa = wrap_degrees(longint'(pitch) + off_pitch);
        ya = wrap_degrees(-(longint'(yaw) + off_yaw));
        sp = sine_of(pa);
        cp = sine_of((pa + 11520) % 46080);
        sy = sine_of(ya);
        cy = sine_of((ya + 11520) % 46080);
        v = '{default: 0};
        if (cp == 0) begin
            v.degenerate = 1;
        end else begin
            s = (cp > 0) ? 1 : -1;
            sx = -s * sy;
            sz = s * cy;
            ux = -s * round_shift(cy * sp, 14);
            uy = (cp > 0) ? cp : -cp;
            uz = -s * round_shift(sy * sp, 14);
            fx = round_shift(cy * cp, 14);
            fy = sp;
            fz = round_shift(sy * cp, 14);
            v.side_x = int'(sx); v.side_z = int'(sz);
            v.up_x = int'(ux); v.up_y = int'(uy); v.up_z = int'(uz);
            v.back_x = int'(-fx); v.back_y = int'(-fy); v.back_z = int'(-fz);
            v.trans_x = int'(clamp32(-round_shift(sx * ex + sz * ez, 14)));
            v.trans_y = int'(clamp32(-round_shift(ux * ex + uy * ey + uz * ez, 14)));
            v.trans_z = int'(clamp32(round_shift(fx * ex + fy * ey + fz * ez, 14)));
        end
        pending = {pending, v};
    endfunction

    function void compare(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_view(t_view_rec got);
        t_view_rec want;
        results++;
        if (pending.size() == 0) begin
            $error("result transfer with no pose outstanding");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (want.degenerate) degenerate_seen++;
        compare("side_x", want.side_x, got.side_x);
        compare("side_z", want.side_z, got.side_z);
        compare("up_x", want.up_x, got.up_x);
        compare("up_y", want.up_y, got.up_y);
        compare("up_z", want.up_z, got.up_z);
        compare("back_x", want.back_x, got.back_x);
        compare("back_y", want.back_y, got.back_y);
        compare("back_z", want.back_z, got.back_z);
        compare("trans_x", want.trans_x, got.trans_x);
        compare("trans_y", want.trans_y, got.trans_y);
        compare("trans_z", want.trans_z, got.trans_z);
        compare("degenerate", int'(want.degenerate), int'(got.degenerate));
    endfunction
endclass

module tb_euler_camera_view_matrix_unit
    import ecvm_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit idle_enable = 1'b1;
    int quiet_cycles = 0;
    int poses_sent = 0;

    ecvm_in_if  pose_ch();
    ecvm_out_if view_ch();
    ecvm_cfg_if cfg_ch();

    t_view_scoreboard board = new();

    euler_camera_view_matrix_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pose_ch.sink),
        .o_out  (view_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        pose_ch.valid = 1'b0;
        pose_ch.obj_pos_x = '0;
        pose_ch.obj_pos_y = '0;
        pose_ch.obj_pos_z = '0;
        pose_ch.obj_pitch = '0;
        pose_ch.obj_yaw = '0;
        view_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    always @(posedge i_clk) begin
        t_view_rec got;
        if (i_rst_n && view_ch.valid && view_ch.ready) begin
            got.side_x = int'(view_ch.side_x); got.side_z = int'(view_ch.side_z);
            got.up_x = int'(view_ch.up_x); got.up_y = int'(view_ch.up_y);
            got.up_z = int'(view_ch.up_z);
            got.back_x = int'(view_ch.back_x); got.back_y = int'(view_ch.back_y);
            got.back_z = int'(view_ch.back_z);
            got.trans_x = view_ch.trans_x; got.trans_y = view_ch.trans_y;
            got.trans_z = view_ch.trans_z; got.degenerate = view_ch.degenerate;
            board.check_view(got);
        end
        if (i_rst_n && pose_ch.valid && pose_ch.ready) begin
            board.note_pose(pose_ch.obj_pos_x, pose_ch.obj_pos_y, pose_ch.obj_pos_z,
                            pose_ch.obj_pitch, pose_ch.obj_yaw);
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                view_ch.ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 16) - 1;
                view_ch.ready <= 1'b0;
            end else begin
                view_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pose_ch.valid && pose_ch.ready) || (view_ch.valid && view_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_POS_OFF_X: board.off_x = longint'(signed'(value));
            REG_POS_OFF_Y: board.off_y = longint'(signed'(value));
            REG_POS_OFF_Z: board.off_z = longint'(signed'(value));
            REG_PITCH_OFF: board.off_pitch = longint'(signed'(value[15:0]));
            REG_YAW_OFF:   board.off_yaw = longint'(signed'(value[15:0]));
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] pitch, logic [15:0] yaw);
        int gap;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            pose_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pose_ch.valid <= 1'b1;
        pose_ch.obj_pos_x <= px;
        pose_ch.obj_pos_y <= py;
        pose_ch.obj_pos_z <= pz;
        pose_ch.obj_pitch <= pitch;
        pose_ch.obj_yaw <= yaw;
        do @(posedge i_clk); while (!pose_ch.ready);
        poses_sent++;
    endtask

    task automatic end_burst();
        pose_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_angle();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return 16'(11520 * $urandom_range(0, 5) - 23040);
        if (r == 1) return 16'(11520 * $urandom_range(0, 5) - 23040
                               + $urandom_range(0, 2) - 1);
        if (r == 2) return 16'($urandom_range(0, 46079) - 23040);
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_pos();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        if (r == 1) return 32'($urandom_range(0, 2000000)) - 32'd1000000;
        return $urandom;
    endfunction

    task automatic random_poses(int count);
        repeat (count) send_pose(pick_pos(), pick_pos(), pick_pos(),
                                 pick_angle(), pick_angle());
    endtask

    task automatic random_config(bit extreme);
        logic [31:0] v;
        for (int i = 0; i < 5; i++) begin
            if (extreme) v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            else v = (i < 3) ? pick_pos() : {16'h0, pick_angle()};
            if (extreme && i >= 3) v = v[31] ? 32'h8000 : 32'h7fff;
            write_reg(i[CFG_IDX_W-1:0], v);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pose('0, '0, '0, '0, '0);
        send_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff);
        send_pose(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000);
        send_pose(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'd11520, 16'd5760);
        send_pose(32'h00010000, 32'h00020000, 32'hfffd0000, -16'sd11520, 16'd0);
        send_pose(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 16'd11519, 16'd11520);
        send_pose(32'h00010000, '0, '0, 16'd11521, 16'd23040);
        send_pose(32'h80000000, 32'h7fffffff, 32'h80000000, 16'd23040, -16'sd23040);
        send_pose(32'h55555555, 32'haaaaaaaa, 32'h55555555, 16'd5760, 16'd17280);
        send_pose(32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'd3000, 16'd32767);
        end_burst();

        write_reg(REG_PITCH_OFF, 32'h00007fff);
        write_reg(REG_YAW_OFF, 32'h00008000);
        write_reg(REG_POS_OFF_X, 32'h7fffffff);
        write_reg(REG_POS_OFF_Y, 32'h80000000);
        write_reg(REG_POS_OFF_Z, 32'h7fffffff);
        send_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff);
        send_pose(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000);
        send_pose('0, '0, '0, -16'sd9727, 16'd0);
        random_poses(100);
        end_burst();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                for (int i = 0; i < 5; i++) write_reg(i[CFG_IDX_W-1:0], 32'h0);
                idle_enable = 1'b0;
            end else begin
                random_config(phase == 2);
            end
            random_poses(180);
            end_burst();
        end

        $display("Sent %0d camera poses over several offset settings; %0d results checked,",
                 poses_sent, board.results);
        $display("%0d of them at degenerate pitch.", board.degenerate_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
